// File: hw/rtl/light_gun_aim_mapper_assert.svh
// Assertion macros for the light gun aim mapper.
// Uses clk_i and rst_ni of the including module.
`ifndef LIGHT_GUN_AIM_MAPPER_ASSERT_SVH
`define LIGHT_GUN_AIM_MAPPER_ASSERT_SVH

// Check cons in the same cycle as ante.
`define LGAM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define LGAM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/lgam_pkg.sv
// Types and constants shared by the light gun aim mapper.
// No dependencies.
package lgam_pkg;

  localparam int CORNER_W   = 16;
  localparam int NORM_W     = 20;
  localparam int REPORT_W   = 16;
  localparam int CFG_W      = 20;
  localparam int CFG_IDX_W  = 2;
  localparam int FRAC_W     = 16;  // Q16 fraction of aim and calibration
  localparam int PIX_FRAC_W = 6;   // Q10.6 pixel fraction

  localparam int AXIS_W     = 36;  // line-ratio numerator and denominator
  localparam int AIM_QW     = 20;  // quotient bits of the aim divide
  localparam int CAL_SPAN_W = 21;  // calibration offset and span
  localparam int CAL_QW     = 16;  // quotient bits of the calibration divide

  localparam logic [CFG_IDX_W-1:0] CFG_CAL_LEFT_X   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_TOP_Y    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_RIGHT_X  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_BOTTOM_Y = 2'd3;

  localparam logic signed [NORM_W-1:0]   ONE_Q16      = 20'sd65536;
  localparam logic signed [NORM_W-1:0]   NORM_MAX     = 20'sd524287;
  localparam logic signed [NORM_W-1:0]   NORM_MIN     = -20'sd524288;
  localparam logic signed [16:0]         REPORT_SCALE = 17'sd32767;
  localparam logic signed [REPORT_W-1:0] REPORT_FLOOR = 16'sh8000;

  typedef struct packed {
    logic [CORNER_W-1:0] corner_a_x;
    logic [CORNER_W-1:0] corner_a_y;
    logic [CORNER_W-1:0] corner_b_x;
    logic [CORNER_W-1:0] corner_b_y;
    logic [CORNER_W-1:0] corner_c_x;
    logic [CORNER_W-1:0] corner_c_y;
    logic [CORNER_W-1:0] corner_d_x;
    logic [CORNER_W-1:0] corner_d_y;
  } corners_t;

  typedef struct packed {
    logic signed [NORM_W-1:0]   norm_aim_x;
    logic signed [NORM_W-1:0]   norm_aim_y;
    logic signed [REPORT_W-1:0] report_x;
    logic signed [REPORT_W-1:0] report_y;
    logic                       degenerate;
  } aim_result_t;

endpackage

// File: hw/rtl/lgam_udiv.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Stand-alone; stage enables come from the instantiating pipeline.
module lgam_udiv #(
  parameter int QW = 20,
  parameter int DW = 36,
  parameter int SW = 3
) (
  input  logic             clk_i,
  input  logic [QW-1:0]    en_i,
  input  logic [DW+QW-1:0] x_i,
  input  logic [DW-1:0]    d_i,
  input  logic [SW-1:0]    side_i,
  output logic [QW-1:0]    q_o,
  output logic [SW-1:0]    side_o
);

  localparam int XW = DW + QW;

  logic [XW-1:0] rem_q [QW-1];
  logic [DW-1:0] dv_q  [QW-1];
  logic [QW-1:0] quo_q [QW];
  logic [SW-1:0] sd_q  [QW];

  // x_i must be below d_i << QW so that the quotient fits.
  for (genvar k = 0; k < QW; k++) begin : g_step
    localparam int Sh = QW - 1 - k;
    logic [XW-1:0] r_in;
    logic [XW-1:0] d_sh;
    logic [DW-1:0] d_in;
    logic [QW-1:0] q_in;
    logic [SW-1:0] s_in;
    logic          take;

    if (k == 0) begin : g_first
      assign r_in = x_i;
      assign d_in = d_i;
      assign q_in = '0;
      assign s_in = side_i;
    end else begin : g_next
      assign r_in = rem_q[k-1];
      assign d_in = dv_q[k-1];
      assign q_in = quo_q[k-1];
      assign s_in = sd_q[k-1];
    end

    assign d_sh = XW'(d_in) << Sh;
    assign take = r_in >= d_sh;

    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        quo_q[k] <= q_in | (take ? (QW'(1) << Sh) : '0);
        sd_q[k]  <= s_in;
      end
    end

    if (k < QW - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i[k]) begin
          rem_q[k] <= take ? r_in - d_sh : r_in;
          dv_q[k]  <= d_in;
        end
      end
    end
  end

  assign q_o    = quo_q[QW-1];
  assign side_o = sd_q[QW-1];

endmodule

// File: hw/rtl/light_gun_aim_mapper.sv
// Light gun aim mapper: four LED corners in, normalized aim and reports out.
// One item per cycle while stall_o is low.
// Depth is set by the 20-step aim divider and the 16-step calibration divider.
// A stall backs up only as far as the first empty stage.
// Reset clears all stage valid bits and loads the default calibration window.
module light_gun_aim_mapper #(
  parameter int CAMERA_WIDTH  = 640,
  parameter int CAMERA_HEIGHT = 480
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input channel
  input  logic                           valid_i,
  output logic                           stall_o,
  input  lgam_pkg::corners_t             corners_i,
  // result channel
  output logic                           valid_o,
  input  logic                           stall_i,
  output lgam_pkg::aim_result_t          result_o,
  // configuration write port
  input  logic                           cfg_we_i,
  input  logic [lgam_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [lgam_pkg::CFG_W-1:0]     cfg_wdata_i
);

  import lgam_pkg::*;

  `include "light_gun_aim_mapper_assert.svh"

  // Stage map: products, sums, magnitudes, overflow test, aim divide,
  // aim saturate, calibration offset, magnitudes, overflow test,
  // calibration divide, scale multiply, report rounding.
  localparam int StProd   = 0;
  localparam int StSum    = 1;
  localparam int StAbs    = 2;
  localparam int StOvf    = 3;
  localparam int StDivA   = 4;
  localparam int StAim    = StDivA + AIM_QW;
  localparam int StCal    = StAim + 1;
  localparam int StCalAbs = StCal + 1;
  localparam int StCalOvf = StCalAbs + 1;
  localparam int StDivC   = StCalOvf + 1;
  localparam int StScale  = StDivC + CAL_QW;
  localparam int StOut    = StScale + 1;
  localparam int NumSt    = StOut + 1;

  localparam int AimXW = AXIS_W + AIM_QW;
  localparam int CalSW = NORM_W + 3;

  // Camera center in Q10.6 pixels.
  localparam logic signed [16:0] CamCx = 17'((CAMERA_WIDTH / 2) << PIX_FRAC_W);
  localparam logic signed [16:0] CamCy = 17'((CAMERA_HEIGHT / 2) << PIX_FRAC_W);

  logic signed [CFG_W-1:0] cal_left_x_q, cal_top_y_q, cal_right_x_q, cal_bottom_y_q;

  logic [NumSt-1:0] v_q, v_d, en;

  logic signed [NORM_W-1:0] ax_aim  [2];
  logic                     ax_ok   [2];
  logic signed [32:0]       ax_prod [2];
  logic signed [32:0]       radj    [2];
  logic [REPORT_W-1:0]      rep     [2];
  logic                     ok_all;
  aim_result_t              res_d, res_q;

  // ---------------------------------------------------------------------------
  // Calibration registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_left_x_q   <= '0;
      cal_top_y_q    <= '0;
      cal_right_x_q  <= ONE_Q16;
      cal_bottom_y_q <= ONE_Q16;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CAL_LEFT_X:   cal_left_x_q   <= cfg_wdata_i;
        CFG_CAL_TOP_Y:    cal_top_y_q    <= cfg_wdata_i;
        CFG_CAL_RIGHT_X:  cal_right_x_q  <= cfg_wdata_i;
        CFG_CAL_BOTTOM_Y: cal_bottom_y_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: a stage loads when it is empty or its successor loads,
  // so bubbles collapse and a stalled output only holds the full stages.
  // ---------------------------------------------------------------------------
  always_comb begin
    en[NumSt-1] = !v_q[NumSt-1] || !stall_i;
    for (int k = NumSt - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign v_d = (en & {v_q[NumSt-2:0], valid_i}) | (~en & v_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign stall_o = !en[StProd];
  assign valid_o = v_q[StOut];

  // ---------------------------------------------------------------------------
  // Per-axis datapath. The x axis uses corners a, c, d; the y axis a, b, d.
  // ---------------------------------------------------------------------------
  for (genvar ax = 0; ax < 2; ax++) begin : g_axis
    logic [CORNER_W-1:0]          px, py, qx, qy, rx, ry;
    logic signed [CFG_W-1:0]      lo, hi;
    logic signed [16:0]           dy, dw;
    logic signed [33:0]           pq_q, qp_q, rdy_q, wr_q, dyc_q, wc_q;
    logic signed [AXIS_W-1:0]     dxy, num_q, den_q;
    logic [AXIS_W-1:0]            nabs_q, dabs_q, nabs3_q, dabs3_q;
    logic                         neg2_q, dz2_q, neg3_q, dz3_q, ovf3_q;
    logic [AIM_QW-1:0]            aq;
    logic [2:0]                   aside;
    logic signed [NORM_W-1:0]     aim_d, aim_q, aim25_q, aim26_q, aim27_q, aim44_q;
    logic                         aok_q, ok25_q, ok26_q, ok27_q, ok44_q;
    logic signed [CAL_SPAN_W-1:0] n_q, s_q;
    logic [CAL_SPAN_W-1:0]        nm_q, sm_q, nm27_q, sm27_q;
    logic                         cneg_q, cneg27_q, cov27_q;
    logic [CAL_QW-1:0]            cq;
    logic [CalSW-1:0]             cside;
    logic [CAL_QW:0]              t;
    logic signed [18:0]           v19;
    logic signed [17:0]           vv;
    logic signed [34:0]           prod_full;
    logic signed [32:0]           prod_q;

    if (ax == 0) begin : g_x
      assign qx = corners_i.corner_c_x;
      assign qy = corners_i.corner_c_y;
      assign lo = cal_left_x_q;
      assign hi = cal_right_x_q;
    end else begin : g_y
      assign qx = corners_i.corner_b_x;
      assign qy = corners_i.corner_b_y;
      assign lo = cal_top_y_q;
      assign hi = cal_bottom_y_q;
    end

    assign px = corners_i.corner_a_x;
    assign py = corners_i.corner_a_y;
    assign rx = corners_i.corner_d_x;
    assign ry = corners_i.corner_d_y;

    assign dy = $signed({1'b0, py}) - $signed({1'b0, qy});
    assign dw = $signed({1'b0, qx}) - $signed({1'b0, px});

    // Form all line-ratio products straight from the accepted item.
    always_ff @(posedge clk_i) begin
      if (en[StProd]) begin
        pq_q  <= $signed({1'b0, px}) * $signed({1'b0, qy});
        qp_q  <= $signed({1'b0, qx}) * $signed({1'b0, py});
        rdy_q <= $signed({1'b0, rx}) * dy;
        wr_q  <= dw * $signed({1'b0, ry});
        dyc_q <= dy * CamCx;
        wc_q  <= dw * CamCy;
      end
    end

    assign dxy = AXIS_W'(pq_q) - AXIS_W'(qp_q);

    always_ff @(posedge clk_i) begin
      if (en[StSum]) begin
        den_q <= AXIS_W'(rdy_q) + dxy + AXIS_W'(wr_q);
        num_q <= AXIS_W'(dyc_q) + AXIS_W'(wc_q) + dxy;
      end
    end

    // Split into sign and magnitude; flag a zero denominator.
    always_ff @(posedge clk_i) begin
      if (en[StAbs]) begin
        nabs_q <= num_q[AXIS_W-1] ? -num_q : num_q;
        dabs_q <= den_q[AXIS_W-1] ? -den_q : den_q;
        neg2_q <= num_q[AXIS_W-1] ^ den_q[AXIS_W-1];
        dz2_q  <= den_q == '0;
      end
    end

    // Quotient of 2^20 or more saturates whatever its low bits.
    always_ff @(posedge clk_i) begin
      if (en[StOvf]) begin
        nabs3_q <= nabs_q;
        dabs3_q <= dabs_q;
        neg3_q  <= neg2_q;
        dz3_q   <= dz2_q;
        ovf3_q  <= {4'b0, nabs_q} >= {dabs_q, 4'b0};
      end
    end

    lgam_udiv #(
      .QW(AIM_QW),
      .DW(AXIS_W),
      .SW(3)
    ) u_aim_div (
      .clk_i  (clk_i),
      .en_i   (en[StDivA +: AIM_QW]),
      .x_i    (AimXW'({nabs3_q, {FRAC_W{1'b0}}})),
      .d_i    (dabs3_q),
      .side_i ({neg3_q, ovf3_q, dz3_q}),
      .q_o    (aq),
      .side_o (aside)
    );

    // Apply sign and saturate to Q3.16; a zero denominator gives zero aim.
    always_comb begin
      if (aside[0]) begin
        aim_d = '0;
      end else if (aside[2]) begin
        aim_d = (aside[1] || aq > AIM_QW'(524288)) ? NORM_MIN : $signed(-aq);
      end else begin
        aim_d = (aside[1] || aq[AIM_QW-1]) ? NORM_MAX : $signed(aq);
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[StAim]) begin
        aim_q <= aim_d;
        aok_q <= !aside[0];
      end
    end

    // Offset into the calibration window.
    always_ff @(posedge clk_i) begin
      if (en[StCal]) begin
        n_q     <= CAL_SPAN_W'(aim_q) - CAL_SPAN_W'(lo);
        s_q     <= CAL_SPAN_W'(hi) - CAL_SPAN_W'(lo);
        aim25_q <= aim_q;
        ok25_q  <= aok_q;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[StCalAbs]) begin
        nm_q    <= n_q[CAL_SPAN_W-1] ? -n_q : n_q;
        sm_q    <= s_q[CAL_SPAN_W-1] ? -s_q : s_q;
        cneg_q  <= n_q[CAL_SPAN_W-1] ^ s_q[CAL_SPAN_W-1];
        ok26_q  <= ok25_q && (s_q != '0);
        aim26_q <= aim25_q;
      end
    end

    // An offset at least as large as the span clamps to one unless the ratio is negative.
    always_ff @(posedge clk_i) begin
      if (en[StCalOvf]) begin
        nm27_q   <= nm_q;
        sm27_q   <= sm_q;
        cneg27_q <= cneg_q;
        cov27_q  <= nm_q >= sm_q;
        ok27_q   <= ok26_q;
        aim27_q  <= aim26_q;
      end
    end

    lgam_udiv #(
      .QW(CAL_QW),
      .DW(CAL_SPAN_W),
      .SW(CalSW)
    ) u_cal_div (
      .clk_i  (clk_i),
      .en_i   (en[StDivC +: CAL_QW]),
      .x_i    ({nm27_q, {FRAC_W{1'b0}}}),
      .d_i    (sm27_q),
      .side_i ({aim27_q, cneg27_q, cov27_q, ok27_q}),
      .q_o    (cq),
      .side_o (cside)
    );

    // Clamp to 0..1, then scale (2t - 1) by the report full scale.
    assign t         = cside[2] ? '0 : (cside[1] ? (CAL_QW + 1)'(65536) : {1'b0, cq});
    assign v19       = $signed({1'b0, t, 1'b0}) - 19'sd65536;
    assign vv        = v19[17:0];
    assign prod_full = vv * REPORT_SCALE;

    always_ff @(posedge clk_i) begin
      if (en[StScale]) begin
        prod_q  <= prod_full[32:0];
        aim44_q <= cside[CalSW-1 -: NORM_W];
        ok44_q  <= cside[0];
      end
    end

    assign ax_aim[ax]  = aim44_q;
    assign ax_ok[ax]   = ok44_q;
    assign ax_prod[ax] = prod_q;
  end

  // ---------------------------------------------------------------------------
  // Output stage: divide by 2^16 toward zero and zero the reports when any
  // denominator or span is zero.
  // ---------------------------------------------------------------------------
  always_comb begin
    for (int a = 0; a < 2; a++) begin
      radj[a] = ax_prod[a] + (ax_prod[a][32] ? 33'sd65535 : 33'sd0);
      rep[a]  = radj[a][31:16];
    end
    ok_all           = ax_ok[0] && ax_ok[1];
    res_d.norm_aim_x = ax_aim[0];
    res_d.norm_aim_y = ax_aim[1];
    res_d.report_x   = ok_all ? $signed(rep[0]) : '0;
    res_d.report_y   = ok_all ? $signed(rep[1]) : '0;
    res_d.degenerate = !ok_all;
  end

  always_ff @(posedge clk_i) begin
    if (en[StOut]) begin
      res_q <= res_d;
    end
  end

  assign result_o = res_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `LGAM_ASSERT_NOW(a_stall_full, stall_o, &v_q, "input stalled with an empty stage")
  `LGAM_ASSERT_NEXT(a_accept_enters, valid_i && !stall_o, v_q[StProd], "accepted item lost")
  `LGAM_ASSERT_NOW(a_degen_zero, valid_o && result_o.degenerate, result_o.report_x == '0 && result_o.report_y == '0, "degenerate item with nonzero report")
  `LGAM_ASSERT_NOW(a_report_range, valid_o && !result_o.degenerate, result_o.report_x != REPORT_FLOOR && result_o.report_y != REPORT_FLOOR, "report out of range")

endmodule

// File: bench/testbench.sv
// Self-checking bench for light_gun_aim_mapper: random and directed corner sets.
// Depends on lgam_pkg and the light_gun_aim_mapper RTL; an aim predictor checks every result.
`timescale 1ns / 100ps

module testbench;
  import lgam_pkg::*;

  localparam int CAM_W   = 640;
  localparam int CAM_H   = 480;
  localparam int LATENCY = 45;
  localparam int N_RAND  = 1300;
  localparam int HOLD_N  = 1000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        valid_in = 1'b0;
  logic        stall_in;
  corners_t    corners = '0;
  logic        valid_out;
  logic        stall_out = 1'b0;
  aim_result_t result;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = CFG_CAL_LEFT_X;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  int  n_errors = 0;
  bit  long_hold = 1'b0;

  // Calibration window as the predictor sees it.
  longint win_left = 0, win_top = 0, win_right = 65536, win_bottom = 65536;

  light_gun_aim_mapper #(.CAMERA_WIDTH(CAM_W), .CAMERA_HEIGHT(CAM_H)) i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .valid_i(valid_in), .stall_o(stall_in), .corners_i(corners),
    .valid_o(valid_out), .stall_i(stall_out), .result_o(result),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    n_errors++;
  endtask

  // Line-ratio mapping of the camera center along one axis.
  function automatic bit map_line(input longint px, py, qx, qy, rx, ry, output longint aim);
    longint cx, cy, dy, dxy, den, num, a;
    cx = (CAM_W / 2) * 64;
    cy = (CAM_H / 2) * 64;
    dy = py - qy;
    dxy = px * qy - qx * py;
    den = rx * dy + dxy - px * ry + qx * ry;
    num = dy * cx + (qx - px) * cy + dxy;
    if (den == 0) begin
      aim = 0;
      return 1'b0;
    end
    a = (num * 65536) / den;
    if (a > 524287) a = 524287;
    if (a < -524288) a = -524288;
    aim = a;
    return 1'b1;
  endfunction

  function automatic bit window_report(input longint aim, lo, hi, output longint rep);
    longint span, t;
    span = hi - lo;
    rep = 0;
    if (span == 0) return 1'b0;
    t = ((aim - lo) * 65536) / span;
    if (t < 0) t = 0;
    if (t > 65536) t = 65536;
    rep = ((2 * t - 65536) * 32767) / 65536;
    return 1'b1;
  endfunction

  function automatic aim_result_t predict_aim(input corners_t c);
    aim_result_t r;
    longint nx, ny, rx, ry;
    bit ok;
    ok = map_line(c.corner_a_x, c.corner_a_y, c.corner_c_x, c.corner_c_y,
                  c.corner_d_x, c.corner_d_y, nx);
    ok &= map_line(c.corner_a_x, c.corner_a_y, c.corner_b_x, c.corner_b_y,
                   c.corner_d_x, c.corner_d_y, ny);
    ok &= window_report(nx, win_left, win_right, rx);
    ok &= window_report(ny, win_top, win_bottom, ry);
    if (!ok) begin
      rx = 0;
      ry = 0;
    end
    r.norm_aim_x = nx[NORM_W-1:0];
    r.norm_aim_y = ny[NORM_W-1:0];
    r.report_x   = rx[REPORT_W-1:0];
    r.report_y   = ry[REPORT_W-1:0];
    r.degenerate = ~ok;
    return r;
  endfunction

  class aim_scoreboard;
    aim_result_t pending_aims[$];

    function void note_corners(corners_t c);
      pending_aims.push_back(predict_aim(c));
    endfunction

    task check_result(aim_result_t got);
      aim_result_t want;
      if (pending_aims.size() == 0) begin
        report_mismatch("unexpected result", 0, 0);
        return;
      end
      want = pending_aims.pop_front();
      if (got.norm_aim_x !== want.norm_aim_x)
        report_mismatch("norm_aim_x", $signed(got.norm_aim_x), $signed(want.norm_aim_x));
      if (got.norm_aim_y !== want.norm_aim_y)
        report_mismatch("norm_aim_y", $signed(got.norm_aim_y), $signed(want.norm_aim_y));
      if (got.report_x !== want.report_x)
        report_mismatch("report_x", $signed(got.report_x), $signed(want.report_x));
      if (got.report_y !== want.report_y)
        report_mismatch("report_y", $signed(got.report_y), $signed(want.report_y));
      if (got.degenerate !== want.degenerate)
        report_mismatch("degenerate", got.degenerate, want.degenerate);
    endtask
  endclass

  aim_scoreboard board = new();

  // Monitor: note accepted items on both channels at the edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (valid_in && !stall_in) board.note_corners(corners);
      if (valid_out && !stall_out) board.check_result(result);
    end
  end

  // Receiver stall: random waits per item, one long hold-off on request.
  initial begin
    int wait_n;
    @(posedge rst_n);
    forever begin
      if (long_hold) begin
        stall_out <= 1'b1;
        repeat (HOLD_N) @(posedge clk);
        long_hold = 1'b0;
      end
      wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      if (wait_n > 0) begin
        stall_out <= 1'b1;
        repeat (wait_n) @(posedge clk);
      end
      stall_out <= 1'b0;
      @(posedge clk);
      while (!(valid_out && !stall_out) && !long_hold) @(posedge clk);
    end
  end

  // Hold the item until accepted; draw a gap before it unless burst is set.
  task automatic send_corners(input corners_t c, input bit burst);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 16);
    if (gap > 0 && $urandom_range(0, 2) != 0) begin
      valid_in <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    valid_in <= 1'b1;
    corners  <= c;
    @(posedge clk);
    while (stall_in) @(posedge clk);
  endtask

  task automatic go_idle();
    valid_in <= 1'b0;
    @(posedge clk);
    while (board.pending_aims.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic write_window(input logic [CFG_IDX_W-1:0] idx, input longint v);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= v[CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_CAL_LEFT_X:   win_left   = v;
      CFG_CAL_TOP_Y:    win_top    = v;
      CFG_CAL_RIGHT_X:  win_right  = v;
      CFG_CAL_BOTTOM_Y: win_bottom = v;
      default: ;
    endcase
  endtask

  function automatic logic [15:0] rnd_coord();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom);
      default: return 16'($urandom_range(0, 640 * 64));
    endcase
  endfunction

  // Mostly a plausible screen quad around the camera center, sometimes noise.
  function automatic corners_t rnd_corners();
    corners_t c;
    int x0, y0, x1, y1;
    if ($urandom_range(0, 4) == 0) begin
      c = {$urandom, $urandom, $urandom, $urandom};
      if ($urandom_range(0, 3) == 0) begin
        c.corner_c_x = c.corner_a_x;
        c.corner_c_y = c.corner_a_y;
      end
      return c;
    end
    x0 = $urandom_range(0, 400 * 64);
    y0 = $urandom_range(0, 300 * 64);
    x1 = x0 + $urandom_range(64, 600 * 64);
    y1 = y0 + $urandom_range(64, 450 * 64);
    c.corner_a_x = 16'(x0 + $urandom_range(0, 2000));
    c.corner_a_y = 16'(y0 + $urandom_range(0, 2000));
    c.corner_b_x = 16'(x1 - $urandom_range(0, 2000));
    c.corner_b_y = 16'(y0 + $urandom_range(0, 2000));
    c.corner_c_x = 16'(x0 + $urandom_range(0, 2000));
    c.corner_c_y = 16'(y1 - $urandom_range(0, 2000));
    c.corner_d_x = 16'(x1 - $urandom_range(0, 2000));
    c.corner_d_y = 16'(y1 - $urandom_range(0, 2000));
    if ($urandom_range(0, 15) == 0) c.corner_a_x = rnd_coord();
    return c;
  endfunction

  function automatic longint rnd_cal(input longint lo, input longint hi);
    return longint'($urandom_range(0, 32'(hi - lo))) + lo;
  endfunction

  initial begin
    corners_t c;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    repeat (3) @(posedge clk);

    // Directed: extremes, centered square, zero denominators, saturation.
    send_corners('0, 0);
    send_corners('1, 0);
    send_corners({16'h0000, 16'h0000, 16'hFFFF, 16'h0000,
                  16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 0);
    send_corners({16'd0, 16'd0, 16'd40960, 16'd0,
                  16'd0, 16'd30720, 16'd40960, 16'd30720}, 0);
    send_corners({16'd10240, 16'd7680, 16'd30720, 16'd7680,
                  16'd10240, 16'd23040, 16'd30720, 16'd23040}, 1);
    send_corners({16'd15000, 16'd15000, 16'd15064, 16'd15000,
                  16'd15000, 16'd15064, 16'd15064, 16'd15064}, 1);
    send_corners({16'd100, 16'd100, 16'd200, 16'd100,
                  16'd100, 16'd200, 16'd200, 16'd200}, 1);
    send_corners({16'd40000, 16'd30000, 16'd40900, 16'd30000,
                  16'd40000, 16'd30700, 16'd40900, 16'd30700}, 0);
    send_corners({16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA,
                  16'h1234, 16'hFEDC, 16'h8000, 16'h7FFF}, 0);
    send_corners({16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555,
                  16'hEDCB, 16'h0123, 16'h7FFF, 16'h8000}, 0);
    go_idle();

    // Zero span on both axes, then the extremes of the registers.
    write_window(CFG_CAL_LEFT_X, 0);
    write_window(CFG_CAL_RIGHT_X, 0);
    write_window(CFG_CAL_TOP_Y, 1000);
    write_window(CFG_CAL_BOTTOM_Y, 1000);
    send_corners({16'd10240, 16'd7680, 16'd30720, 16'd7680,
                  16'd10240, 16'd23040, 16'd30720, 16'd23040}, 0);
    go_idle();
    write_window(CFG_CAL_LEFT_X, -524288);
    write_window(CFG_CAL_RIGHT_X, 524287);
    write_window(CFG_CAL_TOP_Y, 524287);
    write_window(CFG_CAL_BOTTOM_Y, -524288);
    for (int i = 0; i < 8; i++) send_corners(rnd_corners(), 0);
    go_idle();

    // Random phases; each reloads the window, one fills the pipe under a long hold.
    for (int ph = 0; ph < 6; ph++) begin
      write_window(CFG_CAL_LEFT_X, rnd_cal(-20000, 20000));
      write_window(CFG_CAL_RIGHT_X, rnd_cal(45000, 85000));
      write_window(CFG_CAL_TOP_Y, rnd_cal(-20000, 20000));
      write_window(CFG_CAL_BOTTOM_Y, rnd_cal(45000, 85000));
      if (ph == 5) begin
        write_window(CFG_CAL_LEFT_X, 0);
        write_window(CFG_CAL_RIGHT_X, 65536);
        write_window(CFG_CAL_TOP_Y, 0);
        write_window(CFG_CAL_BOTTOM_Y, 65536);
      end
      if (ph == 2) long_hold = 1'b1;
      for (int i = 0; i < N_RAND / 6; i++) begin
        c = rnd_corners();
        send_corners(c, (i % 100) < 30);
      end
      go_idle();
    end

    if (n_errors == 0 && board.pending_aims.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

endmodule

// File: light_gun_aim_mapper.f
+incdir+hw/rtl
hw/rtl/lgam_pkg.sv
hw/rtl/lgam_udiv.sv
hw/rtl/light_gun_aim_mapper.sv
bench/testbench.sv
